FILE: src/brsc_pkg.sv
// shared types, constants and helpers for the allocation bitmap block
`default_nettype none
package brsc_pkg;

  localparam int WORD_WIDTH  = 32;
  localparam int NUM_WORDS   = 64;
  localparam int POS_W       = 11;
  localparam int BIT_IDX_W   = $clog2(WORD_WIDTH);
  localparam int WORD_IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int TOTAL_BITS  = WORD_WIDTH * NUM_WORDS;
  localparam int TOT_W       = $clog2(TOTAL_BITS + 1);
  localparam int CMP_W       = (TOT_W > POS_W) ? TOT_W : POS_W;
  localparam int FQ_DEPTH    = 2;
  localparam int FQ_PTR_W    = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
  localparam int FQ_CNT_W    = $clog2(FQ_DEPTH + 1);

  localparam logic [WORD_WIDTH-1:0] WORD_ONES = {WORD_WIDTH{1'b1}};
  localparam logic [BIT_IDX_W-1:0]  TOP_BIT   = BIT_IDX_W'(WORD_WIDTH - 1);

  // request codes; the unused code marks a rejected item
  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TEST  = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  // result status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_UNREG_FREE = 2'd1;
  localparam logic [1:0] ST_INVALID    = 2'd2;

  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [BIT_IDX_W-1:0]  bit_idx_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t       op;
    word_idx_t sw;
    word_idx_t ew;
    bit_idx_t  lo;
    bit_idx_t  hi;
  } brsc_cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

  function automatic logic pos_in_map(input logic [POS_W-1:0] pos);
    logic [CMP_W-1:0] p;
    p = CMP_W'(pos);
    return p < CMP_W'(TOTAL_BITS);
  endfunction

  function automatic word_idx_t pos_word(input logic [POS_W-1:0] pos);
    logic [CMP_W-1:0] p;
    p = CMP_W'(pos) >> BIT_IDX_W;
    return p[WORD_IDX_W-1:0];
  endfunction

  function automatic bit_idx_t pos_bit(input logic [POS_W-1:0] pos);
    return pos[BIT_IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/brsc_front.sv
// front stage: takes request items, checks them and splits the positions into word and bit indices
`default_nettype none
module brsc_front (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [1:0]                in_req_type,
  input  wire  [brsc_pkg::POS_W-1:0] in_first_pos,
  input  wire  [brsc_pkg::POS_W-1:0] in_end_pos,
  output logic                      push_valid,
  input  wire                       push_ready,
  output brsc_pkg::brsc_cmd_t       push_cmd
);
  import brsc_pkg::*;

  logic      cmd_vld_r, cmd_vld_nxt;
  brsc_cmd_t cmd_r, cmd_nxt;
  logic      accept;

  assign in_ready   = !cmd_vld_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = cmd_vld_r;
  assign push_cmd   = cmd_r;

  always_comb begin
    cmd_nxt.sw = pos_word(in_first_pos);
    cmd_nxt.lo = pos_bit(in_first_pos);
    cmd_nxt.ew = pos_word(in_end_pos);
    cmd_nxt.hi = pos_bit(in_end_pos);
    cmd_nxt.op = OP_BAD;
    unique case (op_t'(in_req_type))
      OP_SET, OP_CLEAR: begin
        if (in_first_pos <= in_end_pos && pos_in_map(in_end_pos)) begin
          cmd_nxt.op = op_t'(in_req_type);
        end
      end
      OP_TEST: begin
        // single bit: first and last word coincide
        cmd_nxt.ew = pos_word(in_first_pos);
        cmd_nxt.hi = pos_bit(in_first_pos);
        if (pos_in_map(in_first_pos)) begin
          cmd_nxt.op = OP_TEST;
        end
      end
      OP_BAD: cmd_nxt.op = OP_BAD;
      default: cmd_nxt.op = OP_BAD;
    endcase
  end

  always_comb begin
    if (accept) begin
      cmd_vld_nxt = 1'b1;
    end else if (push_ready) begin
      cmd_vld_nxt = 1'b0;
    end else begin
      cmd_vld_nxt = cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= cmd_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: src/brsc_queue.sv
// short command queue between front and back
`default_nettype none
module brsc_queue (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push_valid,
  output logic                 push_ready,
  input  brsc_pkg::brsc_cmd_t  push_cmd,
  output logic                 pop_valid,
  input  wire                  pop,
  output brsc_pkg::brsc_cmd_t  pop_cmd
);
  import brsc_pkg::*;

  brsc_cmd_t            ent_r [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign push_ready = cnt_r != FQ_CNT_W'(FQ_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = ent_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

FILE: src/brsc_back.sv
// back end: bitmap memory and per-word read-modify-write sequencer
`default_nettype none
module brsc_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  check_before_free,
  input  wire                  q_valid,
  output logic                 q_pop,
  input  brsc_pkg::brsc_cmd_t  q_cmd,
  output logic                 out_valid,
  input  wire                  out_ready,
  output logic                 out_bit_value,
  output logic [1:0]           out_status
);
  import brsc_pkg::*;

  // bitmap storage; per-word valid flags stand in for the reset clear
  logic [WORD_WIDTH-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0]  vld_r;
  logic [WORD_WIDTH-1:0] rd_data_r;
  logic                  rd_vld_r;

  bk_state_t  state_r, state_nxt;
  brsc_cmd_t  cmd_r, cmd_nxt;
  word_idx_t  cur_r, cur_nxt;
  logic       missing_r, missing_nxt;
  logic       bit_r, bit_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_bit_r;
  logic [1:0]            out_status_r;
  logic                  out_load;
  logic [1:0]            status_val;

  logic [WORD_WIDTH-1:0] word_cur, mask, wr_data;
  bit_idx_t              lo_sel, hi_sel;
  logic                  wr_en;

  assign word_cur = rd_vld_r ? rd_data_r : '0;
  assign lo_sel   = (cur_r == cmd_r.sw) ? cmd_r.lo : '0;
  assign hi_sel   = (cur_r == cmd_r.ew) ? cmd_r.hi : TOP_BIT;
  assign mask     = (WORD_ONES << lo_sel) & (WORD_ONES >> (TOP_BIT - hi_sel));

  always_comb begin
    if (cmd_r.op == OP_BAD) begin
      status_val = ST_INVALID;
    end else if (cmd_r.op == OP_CLEAR && check_before_free && missing_r) begin
      status_val = ST_UNREG_FREE;
    end else begin
      status_val = ST_OK;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    cur_nxt     = cur_r;
    missing_nxt = missing_r;
    bit_nxt     = bit_r;
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    wr_data     = word_cur | mask;
    out_load    = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop       = 1'b1;
          cmd_nxt     = q_cmd;
          cur_nxt     = q_cmd.sw;
          missing_nxt = 1'b0;
          bit_nxt     = 1'b0;
          state_nxt   = (q_cmd.op == OP_BAD) ? BK_DONE : BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_WRITE;
      end
      BK_WRITE: begin
        case (cmd_r.op)
          OP_SET: begin
            wr_en   = 1'b1;
            wr_data = word_cur | mask;
          end
          OP_CLEAR: begin
            wr_en   = 1'b1;
            wr_data = word_cur & ~mask;
            if ((word_cur & mask) != mask) begin
              missing_nxt = 1'b1;
            end
          end
          OP_TEST: begin
            bit_nxt = word_cur[cmd_r.lo];
          end
          default: begin
          end
        endcase
        if (cur_r == cmd_r.ew || cmd_r.op == OP_TEST) begin
          state_nxt = BK_DONE;
        end else begin
          cur_nxt   = cur_r + 1'b1;
          state_nxt = BK_READ;
        end
      end
      BK_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        vld_r[cur_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    cur_r     <= cur_nxt;
    missing_r <= missing_nxt;
    bit_r     <= bit_nxt;
    if (out_load) begin
      out_bit_r    <= bit_r;
      out_status_r <= status_val;
    end
  end

  // memory port: registered read, one write
  always_ff @(posedge clk) begin
    if (state_r == BK_READ) begin
      rd_data_r <= mem[cur_r];
      rd_vld_r  <= vld_r[cur_r];
    end
    if (wr_en) begin
      mem[cur_r] <= wr_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_bit_value = out_bit_r;
  assign out_status    = out_status_r;

endmodule
`default_nettype wire

FILE: src/bitmap_range_set_clear_core.sv
// path: front register, two-entry queue, then back states IDLE, READ and WRITE per word, DONE
// the back takes one item at a time while the front and queue accept further items
// the bound is the single memory port: one read and one write per touched word of a set or clear
// reset: synchronous active-low; bitmap reads all zero through per-word valid flags
// reset: no clearing pass; check_before_free comes up as 1
`default_nettype none
module bitmap_range_set_clear_core (
  input  wire                        clk,
  input  wire                        rst_n,
  // request items
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire  [1:0]                 in_req_type,
  input  wire  [brsc_pkg::POS_W-1:0] in_first_pos,
  input  wire  [brsc_pkg::POS_W-1:0] in_end_pos,
  // result items
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic                       out_bit_value,
  output logic [1:0]                 out_status,
  // configuration write
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire                        cfg_check_before_free
);
  import brsc_pkg::*;

  // config register, always writable
  logic      check_r;

  // front to queue
  logic      push_valid;
  logic      push_ready;
  brsc_cmd_t push_cmd;

  // queue to back
  logic      q_valid;
  logic      q_pop;
  brsc_cmd_t q_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      check_r <= cfg_check_before_free;
    end
  end

  // front: range checks and split into first/last word and bit offsets
  brsc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_req_type  (in_req_type),
    .in_first_pos (in_first_pos),
    .in_end_pos   (in_end_pos),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_cmd     (push_cmd)
  );

  // two-entry queue decouples classification from the memory sequencer
  brsc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  // back: one read-modify-write per word (a read only for test), result held in an output register
  brsc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .check_before_free (check_r),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_cmd             (q_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_bit_value     (out_bit_value),
    .out_status        (out_status)
  );

endmodule
`default_nettype wire

FILE: src/brsc_chk.sv
// port-level checker for the allocation bitmap block, bound to the top level
`default_nettype none
module brsc_chk (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire       out_bit_value,
  input wire [1:0] out_status
);
  import brsc_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_bit_value))
    else $error("result changed while stalled");

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_UNREG_FREE ||
                   out_status == ST_INVALID))
    else $error("undefined status code");

  // a set bit value only comes with an ok status
  a_bit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bit_value |-> out_status == ST_OK)
    else $error("bit value reported with error status");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind bitmap_range_set_clear_core brsc_chk u_brsc_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_bit_value (out_bit_value),
  .out_status    (out_status)
);
`default_nettype wire
